// ===== sv/min_coin_change_dp_defines.svh =====
// assertion helpers shared by the rtl
`ifndef MIN_COIN_CHANGE_DP_DEFINES_SVH
`define MIN_COIN_CHANGE_DP_DEFINES_SVH

// same-cycle implication
`define MCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcc assertion failed");

// next-cycle implication
`define MCC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcc assertion failed");

`endif

// ===== sv/mcc_pkg.sv =====
`timescale 1ns / 1ps

package mcc_pkg;

  localparam int MAX_COINS_DEF = 128;
  localparam int MAX_SUM_DEF   = 65536;

  localparam int VAL_W  = 16;
  localparam int BEST_W = 17;

  localparam logic [BEST_W-1:0] UNREACH = {BEST_W{1'b1}};

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_INIT  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
  } coin_ctl_t;

endpackage

// ===== sv/mcc_if.sv =====
`timescale 1ns / 1ps

interface mcc_in_if;
  import mcc_pkg::*;

  logic             valid;
  logic             ready;
  logic             opcode;
  logic [VAL_W-1:0] coin_value;
  logic [VAL_W-1:0] target_sum;

  modport source (output valid, opcode, coin_value, target_sum, input ready);
  modport sink   (input valid, opcode, coin_value, target_sum, output ready);
endinterface

interface mcc_out_if;
  import mcc_pkg::*;

  logic             valid;
  logic             ready;
  logic             reachable;
  logic [VAL_W-1:0] min_coins;

  modport source (output valid, reachable, min_coins, input ready);
  modport sink   (input valid, reachable, min_coins, output ready);
endinterface

// ===== sv/mcc_coin_store.sv =====
`timescale 1ns / 1ps

module mcc_coin_store #(
  parameter int MAX_COINS = mcc_pkg::MAX_COINS_DEF,
  parameter int CIW       = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1,
  parameter int CNTW      = $clog2(MAX_COINS + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mcc_pkg::coin_ctl_t       ctl,
  input  logic [mcc_pkg::VAL_W-1:0] wr_value,
  input  logic [CIW-1:0]           rd_addr,
  output logic [mcc_pkg::VAL_W-1:0] rd_data_r,
  output logic [CNTW-1:0]          count_r
);
  import mcc_pkg::*;

  logic [VAL_W-1:0] coin_mem [MAX_COINS];
  logic [CNTW-1:0]  count_nxt;
  logic             wr_en;

  assign wr_en = ctl.load && (wr_value != '0) && (32'(count_r) < 32'(MAX_COINS));

  always_comb begin
    count_nxt = count_r;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (wr_en) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      coin_mem[count_r[CIW-1:0]] <= wr_value;
    end
    rd_data_r <= coin_mem[rd_addr];
  end

endmodule

// ===== sv/min_coin_change_dp.sv =====
`timescale 1ns / 1ps
// minimum-coin change engine
// in_ch carries transactions: opcode 0 appends coin_value to the coin table
// (zero coins and coins past MAX_COINS are dropped), opcode 1 solves for
// target_sum and produces exactly one transaction on out_ch with reachable
// and min_coins (0 when not reachable); every solve empties the coin table.
// a load leaves the engine idle, so the next transaction may follow at once.
// a solve with target T and N coins walks sums 1..T, reading each coin from
// the coin ram and dp[sum-coin] from the best-count ram, one coin per cycle
// with a two-deep read pipeline drained before dp[sum] is written back.
// targets of 0, targets >= MAX_SUM and an empty table skip the walk.
// in_ch.ready is low while a solve runs.
// the result sits in an output register; a stalled receiver does not block
// coin loads, only the end of the next solve.
// reset (rst_n, synchronous) clears the coin count and the control state;
// neither ram needs a clearing pass.
`include "min_coin_change_dp_defines.svh"

module min_coin_change_dp #(
  parameter int MAX_COINS = mcc_pkg::MAX_COINS_DEF,
  parameter int MAX_SUM   = mcc_pkg::MAX_SUM_DEF
) (
  input logic      clk,
  input logic      rst_n,
  mcc_in_if.sink   in_ch,
  mcc_out_if.source out_ch
);
  import mcc_pkg::*;

  localparam int CIW  = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam int CNTW = $clog2(MAX_COINS + 1);
  localparam int SW   = $clog2(MAX_SUM);

  state_t            state_r, state_nxt;
  logic [SW-1:0]     s_r, s_nxt;
  logic [SW-1:0]     tgt_r, tgt_nxt;
  logic [CNTW-1:0]   k_r, k_nxt;
  logic              p1_v_r, p1_v_nxt;
  logic              p2_v_r, p2_v_nxt;
  logic [BEST_W-1:0] acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_reach_r, out_reach_nxt;
  logic [VAL_W-1:0]  out_min_r, out_min_nxt;

  coin_ctl_t         coin_ctl;
  logic [VAL_W-1:0]  coin_rd_r;
  logic [CNTW-1:0]   coin_count;

  logic [BEST_W-1:0] best_mem [MAX_SUM];
  logic [BEST_W-1:0] best_rd_r;
  logic              best_we;
  logic [SW-1:0]     best_waddr;
  logic [BEST_W-1:0] best_wdata;
  logic [SW-1:0]     best_raddr;

  logic              in_acc;
  logic              fits;
  logic [BEST_W-1:0] cand;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.reachable = out_reach_r;
  assign out_ch.min_coins = out_min_r;

  mcc_coin_store #(
    .MAX_COINS (MAX_COINS),
    .CIW       (CIW),
    .CNTW      (CNTW)
  ) u_coin_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (coin_ctl),
    .wr_value  (in_ch.coin_value),
    .rd_addr   (k_r[CIW-1:0]),
    .rd_data_r (coin_rd_r),
    .count_r   (coin_count)
  );

  // stage 1: coin is back, address dp[s - coin]
  assign fits       = p1_v_r && (32'(coin_rd_r) <= 32'(s_r));
  assign best_raddr = SW'(32'(s_r) - 32'(coin_rd_r));
  // stage 2: dp value is back
  assign cand       = best_rd_r + 1'b1;

  always_ff @(posedge clk) begin
    if (best_we) begin
      best_mem[best_waddr] <= best_wdata;
    end
    best_rd_r <= best_mem[best_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    s_nxt         = s_r;
    tgt_nxt       = tgt_r;
    k_nxt         = k_r;
    p1_v_nxt      = 1'b0;
    p2_v_nxt      = fits;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_reach_nxt = out_reach_r;
    out_min_nxt   = out_min_r;
    coin_ctl      = '0;
    best_we       = 1'b0;
    best_waddr    = s_r;
    best_wdata    = acc_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (p2_v_r && (best_rd_r != UNREACH) && (cand < acc_r)) begin
      acc_nxt = cand;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.opcode == OP_LOAD) begin
            coin_ctl.load = 1'b1;
          end else if (32'(in_ch.target_sum) >= 32'(MAX_SUM)) begin
            acc_nxt   = UNREACH;
            state_nxt = ST_DONE;
          end else if (in_ch.target_sum == '0) begin
            acc_nxt   = '0;
            state_nxt = ST_DONE;
          end else if (coin_count == '0) begin
            acc_nxt   = UNREACH;
            state_nxt = ST_DONE;
          end else begin
            tgt_nxt   = SW'(in_ch.target_sum);
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        best_we    = 1'b1;
        best_waddr = '0;
        best_wdata = '0;
        s_nxt      = SW'(1);
        k_nxt      = '0;
        acc_nxt    = UNREACH;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        p1_v_nxt = 1'b1;
        k_nxt    = k_r + 1'b1;
        if (k_r == CNTW'(coin_count - 1'b1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_v_r && !p2_v_r) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        best_we = 1'b1;
        if (s_r == tgt_r) begin
          state_nxt = ST_DONE;
        end else begin
          s_nxt     = s_r + 1'b1;
          k_nxt     = '0;
          acc_nxt   = UNREACH;
          state_nxt = ST_SCAN;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_reach_nxt  = (acc_r != UNREACH);
          out_min_nxt    = (acc_r != UNREACH) ? acc_r[VAL_W-1:0] : '0;
          coin_ctl.clear = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p1_v_r      <= p1_v_nxt;
      p2_v_r      <= p2_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r         <= s_nxt;
    tgt_r       <= tgt_nxt;
    k_r         <= k_nxt;
    acc_r       <= acc_nxt;
    out_reach_r <= out_reach_nxt;
    out_min_r   <= out_min_nxt;
  end

  // a dp read only follows a coin read
  `MCC_ASSERT_IMP(a_pipe_order, clk, rst_n, p2_v_r, $past(p1_v_r))
  // no read in flight when dp[s] is written back
  `MCC_ASSERT_IMP(a_write_drained, clk, rst_n, state_r == ST_WRITE, !p1_v_r && !p2_v_r)
  // a solve always leaves idle
  `MCC_ASSERT_NXT(a_solve_starts, clk, rst_n, in_acc && (in_ch.opcode == OP_SOLVE),
                  state_r != ST_IDLE)
  // unreachable results carry a zero count
  `MCC_ASSERT_IMP(a_unreach_zero, clk, rst_n, out_valid_r && !out_reach_r, out_min_r == '0)

endmodule

// ===== tb/min_coin_change_dp_checker.sv =====
`timescale 1ns / 1ps

module min_coin_change_dp_checker (
  input  logic        clk,
  input  logic        rst_n,
  mcc_in_if           in_mon,
  mcc_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned pending_results
);
  import mcc_pkg::*;

  typedef struct packed {
    logic             reachable;
    logic [VAL_W-1:0] min_coins;
  } change_result_t;

  logic [VAL_W-1:0]  coin_list [MAX_COINS_DEF];
  int unsigned       coin_cnt;
  logic [BEST_W-1:0] best_by_sum [MAX_SUM_DEF];
  change_result_t    expected_q [$];
  int unsigned       errs;

  assign fail_count = errs;

  // fewest coins per sum, walking sums upward from zero
  function automatic change_result_t predict_change(input logic [VAL_W-1:0] target);
    change_result_t    res;
    logic [BEST_W-1:0] best;
    logic [BEST_W-1:0] prev;
    int                s;
    int                k;
    int                c;
    best_by_sum[0] = '0;
    for (s = 1; s <= int'(target); s++) begin
      best = UNREACH;
      for (k = 0; k < int'(coin_cnt); k++) begin
        c = int'(coin_list[k]);
        if (c <= s) begin
          prev = best_by_sum[s - c];
          if (prev != UNREACH && BEST_W'(prev + 1'b1) < best) begin
            best = BEST_W'(prev + 1'b1);
          end
        end
      end
      best_by_sum[s] = best;
    end
    res.reachable = (best_by_sum[target] != UNREACH);
    res.min_coins = res.reachable ? best_by_sum[target][VAL_W-1:0] : '0;
    return res;
  endfunction

  always @(posedge clk) begin
    change_result_t got;
    change_result_t exp_res;
    if (!rst_n) begin
      coin_cnt = 0;
      expected_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.opcode == OP_LOAD) begin
          if (in_mon.coin_value != '0 && coin_cnt < MAX_COINS_DEF) begin
            coin_list[coin_cnt] = in_mon.coin_value;
            coin_cnt++;
          end
        end else begin
          expected_q.push_back(predict_change(in_mon.target_sum));
          coin_cnt = 0;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got.reachable = out_mon.reachable;
        got.min_coins = out_mon.min_coins;
        if (expected_q.size() == 0) begin
          if (errs < 10) begin
            $display("%0t: unexpected result transaction reachable=%0d min_coins=%0d",
                     $realtime, got.reachable, got.min_coins);
          end
          errs++;
        end else begin
          exp_res = expected_q.pop_front();
          if (got.reachable !== exp_res.reachable || got.min_coins !== exp_res.min_coins) begin
            if (errs < 10) begin
              $display({"%0t: mismatch expected reachable=%0d min_coins=%0d, ",
                        "got reachable=%0d min_coins=%0d"},
                       $realtime, exp_res.reachable, exp_res.min_coins,
                       got.reachable, got.min_coins);
            end
            errs++;
          end
        end
      end
    end
    pending_results <= expected_q.size();
  end

endmodule

// ===== tb/min_coin_change_dp_tb.sv =====
`timescale 1ns / 1ps

module min_coin_change_dp_tb;
  import mcc_pkg::*;

  localparam int unsigned HOLD_CYCLES = 4000;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned tx_idle_pct = 11;
  int unsigned rx_idle_pct = 48;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned fail_count;
  int unsigned pending_results;

  mcc_in_if  in_ch ();
  mcc_out_if out_ch ();

  min_coin_change_dp DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  min_coin_change_dp_checker change_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always #1 clk = ~clk;

  initial begin
    #20_000_000;
    $display("min_coin_change_dp_tb: done, errors");
    $finish;
  end

  // result side: random stalls, plus one long hold when asked
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_seen = hold_req;
      end
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic send_item(input logic op, input logic [VAL_W-1:0] coin,
                           input logic [VAL_W-1:0] tgt);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < tx_idle_pct) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.coin_value <= coin;
    in_ch.target_sum <= tgt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // coin loads followed by one solve; the first batch may overfill the table
  task automatic run_phase(input int unsigned budget, input bit overfill);
    int unsigned      sent;
    int unsigned      nloads;
    int unsigned      nz;
    int unsigned      r;
    bit               first;
    logic [VAL_W-1:0] coin;
    logic [VAL_W-1:0] tgt;
    sent = 0;
    first = 1'b1;
    while (sent < budget) begin
      if (first && overfill) begin
        nloads = MAX_COINS_DEF + $urandom_range(1, 6);
      end else begin
        nloads = $urandom_range(0, 9);
      end
      nz = 0;
      repeat (nloads) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          coin = '0;
        end else if (r < 16) begin
          coin = VAL_W'($urandom);
        end else begin
          coin = VAL_W'($urandom_range(1, 24));
        end
        if (coin != '0) nz++;
        send_item(OP_LOAD, coin, VAL_W'($urandom));
        sent++;
      end
      r = $urandom_range(0, 99);
      if (nz == 0 && r < 50) begin
        tgt = VAL_W'($urandom);
      end else if (r < 10) begin
        tgt = '0;
      end else begin
        tgt = VAL_W'($urandom_range(1, (nz > 16) ? 40 : 160));
      end
      send_item(OP_SOLVE, VAL_W'($urandom), tgt);
      sent++;
      first = 1'b0;
    end
  endtask

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_LOAD;
    in_ch.coin_value <= '0;
    in_ch.target_sum <= '0;
    rst_n            <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // zero target and huge target on an empty table
    send_item(OP_SOLVE, 16'hFFFF, 16'd0);
    send_item(OP_SOLVE, 16'd0, 16'hFFFF);
    // zero coin is dropped, so the table stays empty
    send_item(OP_LOAD, 16'd0, 16'hFFFF);
    send_item(OP_SOLVE, 16'd0, 16'd5);
    send_item(OP_LOAD, 16'd3, 16'd0);
    send_item(OP_LOAD, 16'd5, 16'd0);
    send_item(OP_LOAD, 16'd0, 16'd0);
    send_item(OP_SOLVE, 16'd0, 16'd11);
    // largest coin and an odd target out of reach
    send_item(OP_LOAD, 16'hFFFF, 16'd0);
    send_item(OP_LOAD, 16'd2, 16'd0);
    send_item(OP_SOLVE, 16'd0, 16'd7);
    // greedy would pick 4+1+1
    send_item(OP_LOAD, 16'd4, 16'd0);
    send_item(OP_LOAD, 16'd1, 16'd0);
    send_item(OP_LOAD, 16'd3, 16'd0);
    send_item(OP_SOLVE, 16'd0, 16'd6);
    // table was emptied by the last solve
    send_item(OP_SOLVE, 16'd0, 16'd1);
    // largest target reached by a single coin
    send_item(OP_LOAD, 16'hFFFF, 16'd0);
    send_item(OP_SOLVE, 16'd0, 16'hFFFF);

    tx_idle_pct = 11;
    rx_idle_pct = 48;
    run_phase(380, 1'b1);

    tx_idle_pct = 48;
    rx_idle_pct = 11;
    run_phase(380, 1'b1);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req <= hold_req + 1;
    run_phase(370, 1'b0);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (fail_count == 0 && pending_results == 0) begin
      $display("min_coin_change_dp_tb: done, clean");
    end else begin
      $display("min_coin_change_dp_tb: done, errors");
    end
    $finish;
  end

endmodule
